>>> hw/rtl/atws_pkg.sv
// Shared types, codes and small helpers of the area-weighted triangle sampler.
package atws_pkg;

  localparam int unsigned CoordW = 24;
  localparam int unsigned AreaW  = 48;
  localparam int unsigned NrmW   = 16;
  localparam int unsigned RowW   = 9 * CoordW;

  localparam logic       OP_ADD    = 1'b0;
  localparam logic       OP_SAMPLE = 1'b1;

  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_MISMATCH = 3'd1;
  localparam logic [2:0] STAT_UNKNOWN  = 3'd2;
  localparam logic [2:0] STAT_FULL     = 3'd3;
  localparam logic [2:0] STAT_EMPTY    = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CROSS,
    S_SQ,
    S_SQRT,
    S_ADDFIN,
    S_TGT,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_VLD,
    S_W2,
    S_PNT,
    S_DIV
  } st_e;

  function automatic logic [1:0] div3(input logic [3:0] n);
    logic [1:0] r;
    case (n)
      4'd0, 4'd1, 4'd2: r = 2'd0;
      4'd3, 4'd4, 4'd5: r = 2'd1;
      4'd6, 4'd7, 4'd8: r = 2'd2;
      default:          r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] mod3(input logic [3:0] n);
    logic [1:0] r;
    case (n)
      4'd0, 4'd3, 4'd6: r = 2'd0;
      4'd1, 4'd4, 4'd7: r = 2'd1;
      4'd2, 4'd5, 4'd8: r = 2'd2;
      default:          r = 2'd0;
    endcase
    return r;
  endfunction

  // Magnitude of a cross-product component; it never exceeds 2^49.
  function automatic logic [49:0] mag51(input logic signed [50:0] c);
    logic signed [50:0] t;
    t = c[50] ? -c : c;
    return t[49:0];
  endfunction

endpackage

>>> hw/rtl/area_weighted_triangle_sampler_top.sv
// Area-weighted triangle sampler: triangle table, CDF search and sample point/normal unit.
// A rejected item answers in the cycle after acceptance; an add runs the cross product,
// the squares on the shared 27x27 multiplier and a 50-step square root; a sample runs the
// search, the square roots and a division per normal component, with the division
// skipped on a degenerate triangle.
// One item is worked at a time; the next is accepted once the result beat is taken.
// Reset empties the table.
module area_weighted_triangle_sampler_top
  import atws_pkg::*;
#(
  parameter int unsigned MAX_TRIANGLES = 256
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     operation_i,
  input  logic [1:0]               triangle_kind_i,
  input  logic signed [CoordW-1:0] ax_i,
  input  logic signed [CoordW-1:0] ay_i,
  input  logic signed [CoordW-1:0] az_i,
  input  logic signed [CoordW-1:0] bx_i,
  input  logic signed [CoordW-1:0] by_coord_i,
  input  logic signed [CoordW-1:0] bz_i,
  input  logic signed [CoordW-1:0] cx_i,
  input  logic signed [CoordW-1:0] cy_i,
  input  logic signed [CoordW-1:0] cz_i,
  input  logic [47:0]              random_bits_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [2:0]               status_o,
  output logic [7:0]               chosen_index_o,
  output logic signed [CoordW-1:0] point_x_o,
  output logic signed [CoordW-1:0] point_y_o,
  output logic signed [CoordW-1:0] point_z_o,
  output logic signed [NrmW-1:0]   normal_x_o,
  output logic signed [NrmW-1:0]   normal_y_o,
  output logic signed [NrmW-1:0]   normal_z_o
);

  localparam int unsigned IW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
  localparam int unsigned CW = $clog2(MAX_TRIANGLES + 1);

  // control state
  st_e             state_q, state_d;
  logic [5:0]      cnt_q, cnt_d;
  logic [1:0]      kidx_q, kidx_d;
  logic            mesh_q;
  logic [CW-1:0]   count_q, count_d;
  logic [AreaW-1:0] total_q, total_d;
  logic            out_valid_q, out_valid_d;

  // payload
  logic            op_q, op_d;
  logic            sqr1_q, sqr1_d;
  logic [15:0]     sel_q, sel_d, r1_q, r1_d, r2_q, r2_d;
  logic signed [CoordW-1:0] v_q [9];
  logic signed [CoordW-1:0] v_d [9];
  logic signed [50:0] c_q [3];
  logic signed [50:0] c_d [3];
  logic [99:0]     acc_q, acc_d, sqx_q, sqx_d;
  logic [49:0]     root_q, root_d;
  logic [51:0]     rem_q, rem_d;
  logic [63:0]     tgt_q, tgt_d;
  logic [IW-1:0]   lo_q, lo_d, hi_q, hi_d;
  logic [16:0]     w0_q, w0_d, w1_q, w1_d, w2_q, w2_d;
  logic signed [43:0] sum_q [3];
  logic signed [43:0] sum_d [3];
  logic [49:0]     drem_q, drem_d;
  logic [14:0]     nlow_q, nlow_d, quo_q, quo_d;
  logic [2:0]      stat_q, stat_d;
  logic [7:0]      idx_q, idx_d;
  logic signed [CoordW-1:0] pt_q [3];
  logic signed [CoordW-1:0] pt_d [3];
  logic signed [NrmW-1:0] nrm_q [3];
  logic signed [NrmW-1:0] nrm_d [3];

  // shared multiplier
  logic signed [26:0] mul_a, mul_b;
  logic signed [53:0] mul_q;

  // table memories
  logic [AreaW-1:0] cum_mem [MAX_TRIANGLES];
  logic [RowW-1:0]  vtx_mem [MAX_TRIANGLES];
  logic [AreaW-1:0] cum_rd_q;
  logic [RowW-1:0]  vtx_rd_q;
  logic [IW-1:0]    rd_addr;
  logic             tbl_we;
  logic [RowW-1:0]  row_wdata;

  logic signed [24:0] e0 [3];
  logic signed [24:0] e1 [3];
  logic [IW:0]        mid_sum;
  logic [IW-1:0]      mid;
  logic               in_fire;

  assign in_ready_o = (state_q == S_IDLE) && !out_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign mid_sum    = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid        = mid_sum[IW:1];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e0[k] = 25'(v_q[3+k]) - 25'(v_q[k]);
      e1[k] = 25'(v_q[6+k]) - 25'(v_q[k]);
    end
    for (int k = 0; k < 9; k++) begin
      row_wdata[k*CoordW +: CoordW] = v_q[k];
    end
  end

  always_comb begin
    logic [3:0]  p;
    logic [1:0]  comp, term;
    logic [49:0] m;
    logic [48:0] asum;
    logic [53:0] rsh, trial;
    logic [64:0] num;
    logic [50:0] dsh, dlen;
    logic [CW-1:0] cm1;
    logic [16:0] wsel;
    logic        qbit;
    logic [43:0] psum;

    state_d = state_q; cnt_d = cnt_q; kidx_d = kidx_q;
    count_d = count_q; total_d = total_q;
    out_valid_d = out_valid_q && !out_ready_i;
    op_d = op_q; sqr1_d = sqr1_q; sel_d = sel_q; r1_d = r1_q; r2_d = r2_q;
    v_d = v_q; c_d = c_q; acc_d = acc_q; sqx_d = sqx_q; root_d = root_q; rem_d = rem_q;
    tgt_d = tgt_q; lo_d = lo_q; hi_d = hi_q;
    w0_d = w0_q; w1_d = w1_q; w2_d = w2_q; sum_d = sum_q;
    drem_d = drem_q; nlow_d = nlow_q; quo_d = quo_q;
    stat_d = stat_q; idx_d = idx_q; pt_d = pt_q; nrm_d = nrm_q;
    mul_a = '0; mul_b = '0;
    rd_addr = lo_q; tbl_we = 1'b0;
    p = 4'(cnt_q - 6'd1);
    comp = '0; term = '0; m = '0; asum = '0; rsh = '0; trial = '0; num = '0;
    dsh = '0; dlen = {1'b0, root_q}; cm1 = count_q - CW'(1); wsel = '0; qbit = 1'b0;
    psum = '0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d  = operation_i;
          sel_d = random_bits_i[15:0];
          r1_d  = random_bits_i[31:16];
          r2_d  = random_bits_i[47:32];
          v_d[0] = ax_i; v_d[1] = ay_i;       v_d[2] = az_i;
          v_d[3] = bx_i; v_d[4] = by_coord_i; v_d[5] = bz_i;
          v_d[6] = cx_i; v_d[7] = cy_i;       v_d[8] = cz_i;
          stat_d = STAT_OK; idx_d = '0;
          for (int k = 0; k < 3; k++) begin
            pt_d[k] = '0; nrm_d[k] = '0;
          end
          cnt_d = '0;
          if (operation_i == OP_ADD) begin
            if (triangle_kind_i != {1'b0, mesh_q}) begin
              stat_d = STAT_MISMATCH; out_valid_d = 1'b1;
            end else if (count_q == CW'(MAX_TRIANGLES)) begin
              stat_d = STAT_FULL; out_valid_d = 1'b1;
            end else begin
              state_d = S_CROSS;
            end
          end else begin
            if (count_q == '0) begin
              stat_d = STAT_EMPTY; out_valid_d = 1'b1;
            end else begin
              lo_d = '0;
              hi_d = cm1[IW-1:0];
              state_d = S_TGT;
            end
          end
        end
      end

      S_CROSS: begin
        case (cnt_q[2:0])
          3'd0: begin mul_a = 27'(e0[1]); mul_b = 27'(e1[2]); end
          3'd1: begin mul_a = 27'(e0[2]); mul_b = 27'(e1[1]); end
          3'd2: begin mul_a = 27'(e0[2]); mul_b = 27'(e1[0]); end
          3'd3: begin mul_a = 27'(e0[0]); mul_b = 27'(e1[2]); end
          3'd4: begin mul_a = 27'(e0[0]); mul_b = 27'(e1[1]); end
          3'd5: begin mul_a = 27'(e0[1]); mul_b = 27'(e1[0]); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
        if (cnt_q != '0) begin
          comp = p[2:1];
          if (!p[0]) c_d[comp] = 51'(mul_q);
          else       c_d[comp] = c_q[comp] - 51'(mul_q);
        end
        if (cnt_q == 6'd6) begin
          state_d = S_SQ; cnt_d = '0; acc_d = '0;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end

      S_SQ: begin
        // each square is split into high and low 25-bit halves
        comp = div3(cnt_q[3:0]);
        term = mod3(cnt_q[3:0]);
        m = mag51(c_q[comp]);
        case (term)
          2'd0:    begin mul_a = {2'b0, m[49:25]}; mul_b = {2'b0, m[49:25]}; end
          2'd1:    begin mul_a = {2'b0, m[49:25]}; mul_b = {2'b0, m[24:0]};  end
          default: begin mul_a = {2'b0, m[24:0]};  mul_b = {2'b0, m[24:0]};  end
        endcase
        if (cnt_q != '0) begin
          case (mod3(p))
            2'd0:    acc_d = acc_q + {mul_q[49:0], 50'b0};
            2'd1:    acc_d = acc_q + {24'b0, mul_q[49:0], 26'b0};
            default: acc_d = acc_q + {50'b0, mul_q[49:0]};
          endcase
        end
        if (cnt_q == 6'd9) begin
          state_d = S_SQRT; cnt_d = '0; sqr1_d = 1'b0;
          sqx_d = acc_d; root_d = '0; rem_d = '0;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end

      S_SQRT: begin
        rsh   = {rem_q, sqx_q[99:98]};
        trial = {2'b0, root_q, 2'b01};
        sqx_d = {sqx_q[97:0], 2'b0};
        if (rsh >= trial) begin
          rem_d  = 52'(rsh - trial);
          root_d = {root_q[48:0], 1'b1};
        end else begin
          rem_d  = rsh[51:0];
          root_d = {root_q[48:0], 1'b0};
        end
        if ((sqr1_q && cnt_q == 6'd15) || (!sqr1_q && cnt_q == 6'd49)) begin
          cnt_d = '0; kidx_d = '0;
          if (sqr1_q)              state_d = S_W2;
          else if (op_q == OP_ADD) state_d = S_ADDFIN;
          else                     state_d = S_DIV;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end

      S_ADDFIN: begin
        asum = {1'b0, total_q} + {12'b0, root_q[49:13]};
        total_d = asum[48] ? {AreaW{1'b1}} : asum[47:0];
        tbl_we  = 1'b1;
        count_d = count_q + CW'(1);
        idx_d   = 8'(count_q);
        out_valid_d = 1'b1;
        state_d = S_IDLE;
      end

      S_TGT: begin
        mul_a = {11'b0, sel_q};
        mul_b = (cnt_q == '0) ? {3'b0, total_q[47:24]} : {3'b0, total_q[23:0]};
        if (cnt_q == 6'd1) tgt_d = {mul_q[39:0], 24'b0};
        if (cnt_q == 6'd2) begin
          tgt_d = tgt_q + {24'b0, mul_q[39:0]};
          state_d = S_SRCH_RD;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end

      S_SRCH_RD: begin
        // once the range closes, the row read here lands in the next cycle
        if (lo_q == hi_q) begin
          rd_addr = lo_q;
          state_d = S_VLD;
        end else begin
          rd_addr = mid;
          state_d = S_SRCH_CMP;
        end
      end

      S_SRCH_CMP: begin
        if ({cum_rd_q, 16'b0} >= tgt_q) hi_d = mid;
        else                            lo_d = mid + IW'(1);
        state_d = S_SRCH_RD;
      end

      S_VLD: begin
        for (int k = 0; k < 9; k++) begin
          v_d[k] = vtx_rd_q[k*CoordW +: CoordW];
        end
        sqx_d = {r1_q, 84'b0};
        root_d = '0; rem_d = '0; sqr1_d = 1'b1; cnt_d = '0;
        state_d = S_SQRT;
      end

      S_W2: begin
        mul_a = {11'b0, root_q[15:0]};
        mul_b = {11'b0, r2_q};
        if (cnt_q == 6'd1) begin
          w2_d = {1'b0, mul_q[31:16]};
          w1_d = {1'b0, root_q[15:0]} - {1'b0, mul_q[31:16]};
          w0_d = 17'h10000 - {1'b0, root_q[15:0]};
          cnt_d = '0;
          state_d = S_PNT;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end

      S_PNT: begin
        // item n multiplies vertex coordinate n by the weight of its vertex
        term = div3(cnt_q[3:0]);
        case (term)
          2'd0:    wsel = w0_q;
          2'd1:    wsel = w1_q;
          default: wsel = w2_q;
        endcase
        mul_a = {10'b0, wsel};
        mul_b = 27'(v_q[cnt_q[3:0]]);
        if (cnt_q != '0) begin
          comp = mod3(p);
          if (div3(p) == 2'd0) sum_d[comp] = 44'(mul_q);
          else                 sum_d[comp] = sum_q[comp] + 44'(mul_q);
        end
        if (cnt_q == 6'd9) begin
          cnt_d = '0; state_d = S_CROSS;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end

      S_DIV: begin
        if (cnt_q == '0) begin
          if (root_q == '0) begin
            for (int k = 0; k < 3; k++) nrm_d[k] = '0;
            state_d = S_IDLE;
            out_valid_d = 1'b1;
          end else begin
            // quotient stays below 2^15, so the top bits start below the divisor
            m = mag51(c_q[kidx_q]);
            num = {1'b0, m, 14'b0} + {16'b0, root_q[49:1]};
            drem_d = num[64:15];
            nlow_d = num[14:0];
            quo_d  = '0;
            cnt_d  = 6'd1;
          end
        end else begin
          dsh = {drem_q, nlow_q[14]};
          qbit = (dsh >= dlen);
          drem_d = qbit ? 50'(dsh - dlen) : dsh[49:0];
          nlow_d = {nlow_q[13:0], 1'b0};
          quo_d  = {quo_q[13:0], qbit};
          if (cnt_q == 6'd15) begin
            nrm_d[kidx_q] = c_q[kidx_q][50] ? -{1'b0, quo_d} : {1'b0, quo_d};
            cnt_d = '0;
            if (kidx_q == 2'd2) begin
              state_d = S_IDLE;
              out_valid_d = 1'b1;
            end else begin
              kidx_d = kidx_q + 2'd1;
            end
          end else begin
            cnt_d = cnt_q + 6'd1;
          end
        end
        if (state_d == S_IDLE) begin
          idx_d = 8'(lo_q);
          for (int k = 0; k < 3; k++) begin
            psum = sum_q[k] + 44'sd32768;
            pt_d[k] = psum[39:16];
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      kidx_q      <= '0;
      mesh_q      <= 1'b0;
      count_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      kidx_q      <= kidx_d;
      count_q     <= count_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) mesh_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d; sqr1_q <= sqr1_d;
    sel_q <= sel_d; r1_q <= r1_d; r2_q <= r2_d;
    v_q <= v_d; c_q <= c_d;
    acc_q <= acc_d; sqx_q <= sqx_d; root_q <= root_d; rem_q <= rem_d;
    tgt_q <= tgt_d; lo_q <= lo_d; hi_q <= hi_d;
    w0_q <= w0_d; w1_q <= w1_d; w2_q <= w2_d; sum_q <= sum_d;
    drem_q <= drem_d; nlow_q <= nlow_d; quo_q <= quo_d;
    stat_q <= stat_d; idx_q <= idx_d; pt_q <= pt_d; nrm_q <= nrm_d;
    mul_q <= mul_a * mul_b;
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      cum_mem[count_q[IW-1:0]] <= total_d;
      vtx_mem[count_q[IW-1:0]] <= row_wdata;
    end
    cum_rd_q <= cum_mem[rd_addr];
    vtx_rd_q <= vtx_mem[rd_addr];
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = stat_q;
  assign chosen_index_o = idx_q;
  assign point_x_o      = pt_q[0];
  assign point_y_o      = pt_q[1];
  assign point_z_o      = pt_q[2];
  assign normal_x_o     = nrm_q[0];
  assign normal_y_o     = nrm_q[1];
  assign normal_z_o     = nrm_q[2];

`ifndef SYNTHESIS
  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("ready while a result beat is pending");
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_TRIANGLES)) else $error("triangle count past table size");
  a_search_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRCH_CMP) |-> (lo_q < hi_q) && (hi_q < count_q))
    else $error("search range invalid");
  a_empty_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == STAT_EMPTY) |-> (count_q == '0))
    else $error("empty status with triangles stored");
  a_add_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ADDFIN) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("add did not advance the count");
`endif

endmodule
